@@ rtl/core/cdc_pkg.sv @@
// Shared types and constants for the command dedup cache.
// Used by cdc_cell, command_dedup_cache and cdc_checker; no dependencies.
`default_nettype none

package cdc_pkg;

	localparam int CACHE_DEPTH_DEF = 8;

	localparam int KEY_W = 32;    // {origin, command code, sequence}
	localparam int ANS_W = 3;     // {led_on, status}
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [1:0] STAT_REJECTED = 2'd0;
	localparam logic [1:0] STAT_EXECUTED = 2'd1;
	localparam logic [1:0] STAT_INVALID  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BOARD_UNIT_ID   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_UNIT_CODE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_CODE  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LED_CMD_CODE    = 8'd3;

	// lookup token walking down the chain
	typedef struct packed {
		logic             hit;
		logic [KEY_W-1:0] key;
		logic [ANS_W-1:0] ans;
	} probe_t;

	// cache entry handed to the next cell on insert
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [ANS_W-1:0] ans;
	} entry_t;

endpackage

`default_nettype wire

@@ rtl/core/cdc_cell.sv @@
// One cache cell: holds one entry and one stage of the lookup chain.
// Depends on cdc_pkg.
`default_nettype none

module cdc_cell
	import cdc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   shift_en,
	input  wire entry_t entry_in,
	output entry_t      entry_out,
	input  wire probe_t probe_in,
	output probe_t      probe_out
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [ANS_W-1:0] ans_q;
	logic             hit_q;
	logic [KEY_W-1:0] pkey_q;
	logic [ANS_W-1:0] pans_q;
	logic             match;

	assign match = valid_q && (key_q == probe_in.key);

	// entries move one cell down on every insert; oldest falls off the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= entry_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			key_q <= entry_in.key;
			ans_q <= entry_in.ans;
		end
	end

	// first hit along the chain wins; keys in the cache are unique anyway
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= probe_in.hit || match;
		end
	end

	always_ff @(posedge clk) begin
		pkey_q <= probe_in.key;
		pans_q <= (!probe_in.hit && match) ? ans_q : probe_in.ans;
	end

	assign entry_out = '{valid: valid_q, key: key_q, ans: ans_q};
	assign probe_out = '{hit: hit_q, key: pkey_q, ans: pans_q};

endmodule

`default_nettype wire

@@ rtl/core/command_dedup_cache.sv @@
// Duplicate command suppression: packet filter, cell-chain cache, answer logic.
// Depends on cdc_pkg and cdc_cell.
//
// Usage:
//   s_* stream carries one received packet descriptor per beat. Packets that
//   are local, addressed elsewhere or sent by this unit produce no beat on m_*.
//   Every other packet produces exactly one acknowledge beat on m_*.
//   cfg_we/cfg_index/cfg_data write the four 8-bit registers; user must write only while idle, block does not check.
// Sequence:
//   Dropped packet: s_tready stays high; the next beat may follow at once.
//   Non-command / wrong component: answer loads from S_DONE once the output register is free.
//   Command: the key walks the chain of CACHE_DEPTH cells, one cell a cycle,
//   in S_PROBE; the answer then loads from S_DONE, and the next beat is taken
//   back in S_IDLE, so no new beat is taken while a command is in the chain.
//   On a miss the new entry is shifted into cell 0 in the same cycle the
//   answer loads; the oldest entry drops off the last cell.
// Reset: all cache entries invalid, registers zero, both streams idle.
// Stall: the answer waits in the output register; one more packet may be
//   taken and worked on, then the block holds it until m_tready frees the
//   output register.
`default_nettype none

module command_dedup_cache
	import cdc_pkg::*;
#(
	parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// packet descriptors
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// dest_unit[7:0], origin_unit[15:8], target_component[23:16],
	// command_code[31:24], sequence_number[47:32], on_value[79:48]
	input  wire logic [79:0]           s_tdata,
	// is_remote[0], is_command[1], on_present[2]
	input  wire logic [2:0]            s_tuser,
	// acknowledges
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// status[1:0], led_update[2], led_on[3], ack_command_code[11:4],
	// ack_sequence[27:12], ack_dest_unit[35:28], zero[39:36]
	output logic [39:0]                m_tdata,
	// duplicate[0]
	output logic                       m_tuser
);

	localparam int CNT_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CACHE_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_PROBE = 3'b010,
		S_DONE  = 3'b100
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	logic [7:0] board_unit_id_q, local_unit_code_q, component_code_q, led_cmd_code_q;

	// held packet
	logic        cmd_ok_q;
	logic [7:0]  origin_q, code_q;
	logic [15:0] seq_q;
	logic        on_present_q;
	logic [31:0] on_value_q;

	logic        in_beat, pass, cmd_ok;
	logic        out_free, finish, insert;

	logic        dup;
	logic [1:0]  status;
	logic        change, level;

	logic        m_tvalid_q;
	logic [35:0] m_data_q;
	logic        m_dup_q;

	probe_t probe_chain [CACHE_DEPTH+1];
	entry_t entry_chain [CACHE_DEPTH+1];

	assign in_beat  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign pass     = s_tuser[0] && (s_tdata[7:0] == board_unit_id_q)
		&& (s_tdata[15:8] != local_unit_code_q);
	assign cmd_ok   = s_tuser[1] && (s_tdata[23:16] == component_code_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = (state_q == S_DONE) && out_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_unit_id_q   <= '0;
			local_unit_code_q <= '0;
			component_code_q  <= '0;
			led_cmd_code_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOARD_UNIT_ID:   board_unit_id_q   <= cfg_data;
				CFG_LOCAL_UNIT_CODE: local_unit_code_q <= cfg_data;
				CFG_COMPONENT_CODE:  component_code_q  <= cfg_data;
				CFG_LED_CMD_CODE:    led_cmd_code_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_beat && pass) begin
						state_q <= cmd_ok ? S_PROBE : S_DONE;
					end
				end
				S_PROBE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_ok_q     <= cmd_ok;
			origin_q     <= s_tdata[15:8];
			code_q       <= s_tdata[31:24];
			seq_q        <= s_tdata[47:32];
			on_present_q <= s_tuser[2];
			on_value_q   <= s_tdata[79:48];
		end
	end

	// cell chain; the key is held steady so the last stage has settled by the
	// time the state reaches S_DONE
	assign probe_chain[0] = '{hit: 1'b0, key: {origin_q, code_q, seq_q}, ans: '0};
	assign entry_chain[0] = '{valid: 1'b1, key: {origin_q, code_q, seq_q},
		ans: {level, status}};

	for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
		cdc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (insert),
			.entry_in  (entry_chain[i]),
			.entry_out (entry_chain[i+1]),
			.probe_in  (probe_chain[i]),
			.probe_out (probe_chain[i+1])
		);
	end

	// answer
	always_comb begin
		dup    = 1'b0;
		status = STAT_REJECTED;
		change = 1'b0;
		level  = 1'b0;
		if (cmd_ok_q) begin
			if (probe_chain[CACHE_DEPTH].hit) begin
				dup    = 1'b1;
				status = probe_chain[CACHE_DEPTH].ans[1:0];
				level  = probe_chain[CACHE_DEPTH].ans[2];
			end else if (code_q == led_cmd_code_q) begin
				if (on_present_q && (on_value_q[31:1] == '0)) begin
					status = STAT_EXECUTED;
					change = 1'b1;
					level  = on_value_q[0];
				end else begin
					status = STAT_INVALID;
				end
			end
		end
	end

	assign insert = finish && cmd_ok_q && !probe_chain[CACHE_DEPTH].hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_data_q <= {origin_q, seq_q, code_q, level, change, status};
			m_dup_q  <= dup;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, m_data_q};
	assign m_tuser  = m_dup_q;

endmodule

`default_nettype wire

@@ rtl/core/cdc_checker.sv @@
// Port-level checks for command_dedup_cache, bound to the top level.
// Depends on cdc_pkg.
`default_nettype none

module cdc_checker
	import cdc_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [39:0]           m_tdata,
	input wire logic                  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// a cached answer never switches the indicator again
	a_dup_no_led: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[2])
		else $error("duplicate beat asks for an LED change");

	// only an executed answer switches the indicator
	a_led_exec: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == STAT_EXECUTED)
		else $error("LED change without executed status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'b11)
		else $error("undefined status code");

endmodule

bind command_dedup_cache cdc_checker u_cdc_checker (.*);

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for command_dedup_cache: descriptor filter, cache hits and LED answers.
// Depends on cdc_pkg and the command_dedup_cache RTL; drives both streams and the config port.
`timescale 1ns / 1ps

module tb_top;
	import cdc_pkg::*;

	localparam int DEPTH = CACHE_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = DEPTH + 6;

	// indexes past the register file; writes must not land anywhere
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

	localparam logic [31:0] ON_INT_MIN   = 32'h8000_0000;
	localparam logic [31:0] ON_INT_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] ON_MINUS_ONE = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        is_remote;
		logic [7:0]  dest;
		logic [7:0]  origin;
		logic        is_cmd;
		logic [7:0]  target;
		logic [7:0]  code;
		logic [15:0] seq;
		logic        on_present;
		logic [31:0] on_value;
	} desc_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        duplicate;
		logic        led_update;
		logic        led_on;
		logic [7:0]  code;
		logic [15:0] seq;
		logic [7:0]  dest;
	} ack_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [79:0]           s_tdata = '0;
	logic [2:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [39:0]           m_tdata;
	logic                  m_tuser;

	command_dedup_cache #(.CACHE_DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// shadow registers and cache image
	logic [7:0]       board_id = '0;
	logic [7:0]       local_code = '0;
	logic [7:0]       comp_code = '0;
	logic [7:0]       led_code = '0;
	logic [KEY_W-1:0] slot_key [DEPTH];
	logic [ANS_W-1:0] slot_ans [DEPTH];
	bit               slot_valid [DEPTH];
	int               rr_ptr = 0;

	ack_t  ack_queue [$];
	desc_t key_hist [$];

	int  n_errors = 0;
	int  n_sent = 0;
	int  n_acks = 0;
	int  n_dups = 0;
	int  n_led = 0;
	int  n_settings = 0;
	int  idle_cycles = 0;
	int  burst_left = 0;
	bit  sender_gaps = 1'b1;
	int  sink_mode = 1;
	int  sink_run = 0;
	bit  sink_ready_phase = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_BOARD_UNIT_ID:   board_id = val;
			CFG_LOCAL_UNIT_CODE: local_code = val;
			CFG_COMPONENT_CODE:  comp_code = val;
			CFG_LED_CMD_CODE:    led_code = val;
			default: ;
		endcase
	endfunction

	// returns 1 when the descriptor earns an acknowledge
	function automatic bit predict_ack(input desc_t d, output ack_t a);
		logic [KEY_W-1:0] key;
		bit hit;
		int i;
		a = '0;
		a.status = STAT_REJECTED;
		a.code = d.code;
		a.seq = d.seq;
		a.dest = d.origin;
		if (!d.is_remote || d.dest != board_id || d.origin == local_code)
			return 1'b0;
		if (d.is_cmd && d.target == comp_code) begin
			key = {d.origin, d.code, d.seq};
			hit = 1'b0;
			for (i = 0; i < DEPTH; i++) begin
				if (!hit && slot_valid[i] && slot_key[i] == key) begin
					a.status = slot_ans[i][1:0];
					a.led_on = slot_ans[i][2];
					a.duplicate = 1'b1;
					hit = 1'b1;
				end
			end
			if (!hit) begin
				if (d.code == led_code) begin
					if (d.on_present && (d.on_value == 32'd0 || d.on_value == 32'd1)) begin
						a.status = STAT_EXECUTED;
						a.led_update = 1'b1;
						a.led_on = d.on_value[0];
					end else begin
						a.status = STAT_INVALID;
					end
				end
				slot_key[rr_ptr] = key;
				slot_ans[rr_ptr] = {a.led_on, a.status};
				slot_valid[rr_ptr] = 1'b1;
				rr_ptr = (rr_ptr + 1) % DEPTH;
			end
		end
		return 1'b1;
	endfunction

	function automatic desc_t mk_cmd(input logic [7:0] origin, input logic [7:0] code,
			input logic [15:0] seq, input logic present, input logic [31:0] value);
		desc_t d;
		d.is_remote = 1'b1;
		d.dest = board_id;
		d.origin = origin;
		d.is_cmd = 1'b1;
		d.target = comp_code;
		d.code = code;
		d.seq = seq;
		d.on_present = present;
		d.on_value = value;
		return d;
	endfunction

	function automatic logic [31:0] pick_on_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 32'd0;
		if (r < 7)
			return 32'd1;
		case (r)
			7: return $urandom;
			8: begin
				case ($urandom_range(0, 2))
					0: return ON_INT_MIN;
					1: return ON_INT_MAX;
					default: return ON_MINUS_ONE;
				endcase
			end
			default: return 32'd2;
		endcase
	endfunction

	// mostly well-formed commands, a third of them reusing a recent key
	function automatic desc_t random_desc();
		desc_t d;
		desc_t old;
		logic [95:0] raw;
		int r;
		d = mk_cmd(8'($urandom), $urandom_range(0, 1) ? led_code : 8'($urandom),
			16'($urandom), $urandom_range(0, 7) != 0, pick_on_value());
		if (d.origin == local_code)
			d.origin = ~d.origin;
		r = $urandom_range(0, 99);
		if (r < 62) begin
			if (key_hist.size() != 0 && $urandom_range(0, 2) == 0) begin
				old = key_hist[$urandom_range(0, key_hist.size() - 1)];
				d.origin = old.origin;
				d.code = old.code;
				d.seq = old.seq;
			end
			key_hist.push_back(d);
			if (key_hist.size() > 20)
				void'(key_hist.pop_front());
		end else if (r < 70) begin
			d.is_cmd = 1'b0;
			d.target = 8'($urandom);
		end else if (r < 78) begin
			d.target = 8'($urandom);
			if (d.target == comp_code)
				d.target = ~d.target;
		end else begin
			case (r % 4)
				0: d.is_remote = 1'b0;
				1: begin
					d.dest = 8'($urandom);
					if (d.dest == board_id)
						d.dest = ~d.dest;
				end
				2: d.origin = local_code;
				default: begin
					raw = {$urandom, $urandom, $urandom};
					d = raw[$bits(desc_t)-1:0];
				end
			endcase
		end
		return d;
	endfunction

	task automatic send_beat(input desc_t d);
		ack_t a;
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 14) : 0;
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {d.on_value, d.seq, d.code, d.target, d.origin, d.dest};
		s_tuser  <= {d.on_present, d.is_cmd, d.is_remote};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_sent++;
		if (predict_ack(d, a))
			ack_queue.push_back(a);
	endtask

	task automatic drain_acks();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (ack_queue.size() != 0)
			@(negedge clk);
		burst_left = 0;
	endtask

	// dropped descriptors leave no expectation, so give the lookup chain time to empty
	task automatic settle();
		drain_acks();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		apply_reg(idx, val);
	endtask

	task automatic program_regs(input logic [7:0] board, input logic [7:0] loc,
			input logic [7:0] comp, input logic [7:0] led);
		settle();
		write_reg(CFG_BOARD_UNIT_ID, board);
		write_reg(CFG_LOCAL_UNIT_CODE, loc);
		write_reg(CFG_COMPONENT_CODE, comp);
		write_reg(CFG_LED_CMD_CODE, led);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic test_reset_defaults();
		send_beat(mk_cmd(8'h01, led_code, 16'h0000, 1'b1, 32'd1));
		send_beat(mk_cmd(8'h00, led_code, 16'h0001, 1'b1, 32'd1));
	endtask

	task automatic test_unused_index();
		settle();
		write_reg(CFG_UNUSED_LO, ~board_id);
		write_reg(CFG_UNUSED_HI, ~led_code);
		@(negedge clk);
		cfg_we <= 1'b0;
		send_beat(mk_cmd(8'h30, led_code, 16'h0100, 1'b1, 32'd1));
	endtask

	task automatic test_filter();
		desc_t d;
		d = mk_cmd(8'h31, led_code, 16'h0200, 1'b1, 32'd1);
		d.is_remote = 1'b0;
		send_beat(d);
		d = mk_cmd(8'h32, led_code, 16'h0201, 1'b1, 32'd1);
		d.dest = ~board_id;
		send_beat(d);
		send_beat(mk_cmd(local_code, led_code, 16'h0202, 1'b1, 32'd1));
	endtask

	task automatic test_led_commands();
		send_beat(mk_cmd(8'h00, led_code, 16'h0000, 1'b1, 32'd0));
		send_beat(mk_cmd(8'hFF, led_code, 16'hFFFF, 1'b1, 32'd1));
		send_beat(mk_cmd(8'h22, led_code, 16'h1234, 1'b0, 32'd1));
		send_beat(mk_cmd(8'h23, led_code, 16'h0001, 1'b1, 32'd2));
		send_beat(mk_cmd(8'h24, led_code, 16'h0002, 1'b1, ON_MINUS_ONE));
		send_beat(mk_cmd(8'h25, led_code, 16'h0003, 1'b1, ON_INT_MIN));
		send_beat(mk_cmd(8'h26, led_code, 16'h0004, 1'b1, ON_INT_MAX));
		// other command codes are rejected but still cached
		send_beat(mk_cmd(8'h27, 8'h00, 16'h0005, 1'b1, 32'd1));
		send_beat(mk_cmd(8'h28, 8'hFF, 16'hAAAA, 1'b1, 32'd0));
	endtask

	task automatic test_rejects();
		desc_t d;
		d = mk_cmd(8'h40, led_code, 16'h0300, 1'b1, 32'd1);
		d.is_cmd = 1'b0;
		send_beat(d);
		send_beat(d);
		d = mk_cmd(8'h41, led_code, 16'h0301, 1'b1, 32'd1);
		d.target = ~comp_code;
		send_beat(d);
	endtask

	task automatic test_duplicates();
		// payload differs from the first beat; the stored answer must come back
		send_beat(mk_cmd(8'hFF, led_code, 16'hFFFF, 1'b1, 32'd0));
		send_beat(mk_cmd(8'h24, led_code, 16'h0002, 1'b1, 32'd1));
		send_beat(mk_cmd(8'h27, 8'h00, 16'h0005, 1'b0, 32'd0));
	endtask

	task automatic run_phase(input int n, input bit gaps, input int sink);
		int pause_at;
		int i;
		pause_at = $urandom_range(n / 4, (3 * n) / 4);
		sender_gaps = gaps;
		sink_mode = sink;
		for (i = 0; i < n; i++) begin
			if (i == pause_at)
				drain_acks();
			send_beat(random_desc());
		end
	endtask

	task automatic test_random_traffic();
		int k;
		program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		run_phase(130, 1'b1, 1);
		program_regs(8'h00, 8'hFF, 8'h00, 8'hFF);
		run_phase(130, 1'b0, 0);
		program_regs(8'hFF, 8'h00, 8'hFF, 8'h00);
		run_phase(130, 1'b1, 2);
		for (k = 0; k < 3; k++) begin
			program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			run_phase(135, 1'b1, $urandom_range(1, 2));
		end
	endtask

	// receiver: always ready in sink mode 0, else runs of ready and stall of random length
	always @(negedge clk) begin
		if (sink_mode == 0) begin
			m_tready <= 1'b1;
		end else begin
			if (sink_run == 0) begin
				sink_ready_phase = !sink_ready_phase;
				if (sink_ready_phase)
					sink_run = $urandom_range(1, 8);
				else
					sink_run = (sink_mode == 2) ? $urandom_range(1, 30) : $urandom_range(1, 3);
			end
			sink_run--;
			m_tready <= sink_ready_phase;
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: ack %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin : ack_monitor
		ack_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (ack_queue.size() == 0) begin
				$display("%0t: ack beat with nothing expected, actual tdata 0x%0h tuser %b",
					$time, m_tdata, m_tuser);
				n_errors++;
			end else begin
				want = ack_queue.pop_front();
				check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
				check_field("led_update", 32'(want.led_update), 32'(m_tdata[2]));
				check_field("led_on", 32'(want.led_on), 32'(m_tdata[3]));
				check_field("command_code", 32'(want.code), 32'(m_tdata[11:4]));
				check_field("sequence", 32'(want.seq), 32'(m_tdata[27:12]));
				check_field("dest_unit", 32'(want.dest), 32'(m_tdata[35:28]));
				check_field("pad", 32'd0, 32'(m_tdata[39:36]));
				check_field("duplicate", 32'(want.duplicate), 32'(m_tuser));
				n_acks++;
				if (want.duplicate)
					n_dups++;
				if (want.led_update)
					n_led++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no beat for %0d cycles, %0d acks outstanding",
					$time, idle_cycles, ack_queue.size());
				$display("*** FAILED ***");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		program_regs(8'h5A, 8'h11, 8'h3C, 8'h42);
		test_unused_index();
		test_filter();
		test_led_commands();
		test_rejects();
		test_duplicates();
		test_random_traffic();

		drain_acks();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run: %0d descriptor beats under %0d register settings, with gaps and stalls",
			n_sent, n_settings);
		$display("Checked %0d acks (%0d from cache, %0d LED changes), %0d mismatches",
			n_acks, n_dups, n_led, n_errors);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ command_dedup_cache.f @@
rtl/core/cdc_pkg.sv
rtl/core/cdc_cell.sv
rtl/core/command_dedup_cache.sv
rtl/core/cdc_checker.sv
dv/tb_top.sv
